[rtl/core/nars_pkg.sv]
`default_nettype none

package nars_pkg;

    localparam int MAX_DEVICES = 8;
    localparam int NODE_BITS   = 4;
    localparam int DEV_IDX_W   = $clog2(MAX_DEVICES);
    localparam int CNT_W       = $clog2(MAX_DEVICES + 1);

    localparam int COUNT_W = 4;
    localparam int NODES_W = 32;
    localparam int CFG_W   = 32;
    localparam int TURN_W  = 32;
    localparam int RETRY_W = 16;

    // request payload: tuser carries mode, tdata the rest
    localparam int MODE_W    = 2;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 24;

    // remainder of the turn + retry sum, one byte of the sum per cycle
    localparam int SUM_W        = TURN_W + 1;
    localparam int DIGIT_BITS   = 8;
    localparam int REDUCE_STEPS = (SUM_W + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int SHIFT_W      = REDUCE_STEPS * DIGIT_BITS;
    localparam int STEP_W       = $clog2(REDUCE_STEPS);

    localparam logic [MODE_W-1:0] MODE_SELECT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CAND    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DISABLE = 2'd2;

    localparam logic [1:0] LOC_NONE    = 2'd0;
    localparam logic [1:0] LOC_UNKNOWN = 2'd1;
    localparam logic [1:0] LOC_REMOTE  = 2'd2;
    localparam logic [1:0] LOC_LOCAL   = 2'd3;

    localparam logic REG_DEVICE_COUNT = 1'b0;
    localparam logic REG_DEVICE_NODES = 1'b1;

    localparam logic [NODE_BITS-1:0] NODE_UNKNOWN = '1;

    typedef struct packed {
        logic load;
        logic reduce;
        logic commit;
    } nars_cmd_t;

    typedef struct packed {
        logic is_select;
        logic out_free;
    } nars_status_t;

endpackage

`default_nettype wire

[rtl/core/nars_ctrl.sv]
`default_nettype none

module nars_ctrl (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  nars_pkg::nars_status_t status,
    output nars_pkg::nars_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_COMMIT
    } state_t;

    localparam logic [nars_pkg::STEP_W-1:0] LAST_STEP =
        nars_pkg::STEP_W'(nars_pkg::REDUCE_STEPS - 1);

    state_t                      state_reg, state_next;
    logic [nars_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd.load   = accept;
        cmd.reduce = (state_reg == ST_REDUCE);
        cmd.commit = (state_reg == ST_COMMIT) && status.out_free;
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    step_next  = '0;
                    state_next = status.is_select ? ST_REDUCE : ST_COMMIT;
                end
            end
            ST_REDUCE: begin
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/nars_datapath.sv]
`default_nettype none

module nars_datapath (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire                                cfg_index,
    input  wire  [nars_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire  [nars_pkg::S_DATA_W-1:0]      s_tdata,
    input  wire  [nars_pkg::MODE_W-1:0]        s_tuser,
    output logic [nars_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    input  nars_pkg::nars_cmd_t                cmd,
    output nars_pkg::nars_status_t             status
);

    localparam int ND = nars_pkg::MAX_DEVICES;
    localparam int NB = nars_pkg::NODE_BITS;

    // configuration and state
    logic [nars_pkg::COUNT_W-1:0] dev_count_reg;
    logic [nars_pkg::NODES_W-1:0] dev_nodes_reg;
    logic [ND-1:0]                enable_reg;
    logic [nars_pkg::TURN_W-1:0]  turn_reg;

    // captured request
    logic [nars_pkg::MODE_W-1:0]    mode_reg;
    logic                           known_reg;
    logic                           aware_reg;
    logic [nars_pkg::DEV_IDX_W-1:0] target_reg;
    logic [ND-1:0]                  live_reg;
    logic [ND-1:0]                  local_reg;
    logic [ND-1:0]                  pool_reg;
    logic [nars_pkg::CNT_W-1:0]     cnt_reg;

    // remainder unit
    logic [nars_pkg::SHIFT_W-1:0]   sum_reg, sum_next;
    logic [nars_pkg::DEV_IDX_W-1:0] rem_reg, rem_next;

    logic [nars_pkg::M_DATA_W-1:0]  m_data_reg;
    logic                           m_valid_reg;

    // request fields
    logic [NB-1:0]                  in_node;
    logic                           in_known;
    logic                           in_aware;
    logic [nars_pkg::RETRY_W-1:0]   in_retry;
    logic [nars_pkg::DEV_IDX_W-1:0] in_target;

    assign in_node   = s_tdata[3:0];
    assign in_known  = s_tdata[4];
    assign in_aware  = s_tdata[5];
    assign in_retry  = s_tdata[21:6];
    assign in_target = s_tdata[24:22];

    logic [nars_pkg::COUNT_W-1:0] present_cnt;
    logic [ND-1:0]                present;
    logic [ND-1:0]                live;
    logic [ND-1:0]                local_live;
    logic [ND-1:0]                pool;
    logic [nars_pkg::CNT_W-1:0]   pool_cnt;
    logic [NB-1:0]                dev_node;

    always_comb begin
        present_cnt = (dev_count_reg > nars_pkg::COUNT_W'(ND)) ?
                      nars_pkg::COUNT_W'(ND) : dev_count_reg;
        pool_cnt = '0;
        for (int i = 0; i < ND; i++) begin
            dev_node      = dev_nodes_reg[i*NB +: NB];
            present[i]    = (nars_pkg::COUNT_W'(i) < present_cnt);
            live[i]       = enable_reg[i] && present[i];
            local_live[i] = live[i] && (dev_node != nars_pkg::NODE_UNKNOWN)
                            && (dev_node == in_node);
        end
        pool = (in_aware && in_known && (local_live != '0)) ? local_live : live;
        for (int i = 0; i < ND; i++) begin
            pool_cnt = pool_cnt + nars_pkg::CNT_W'(pool[i]);
        end
    end

    assign status.is_select = (s_tuser == nars_pkg::MODE_SELECT);
    assign status.out_free  = !m_valid_reg || m_tready;

    // MSB-first remainder: r = (2r + bit) mod cnt, one byte of the sum per cycle
    logic [nars_pkg::DEV_IDX_W:0]   trial;
    logic [nars_pkg::DEV_IDX_W-1:0] r;
    logic [nars_pkg::SHIFT_W-1:0]   sh;

    always_comb begin
        r  = rem_reg;
        sh = sum_reg;
        for (int k = 0; k < nars_pkg::DIGIT_BITS; k++) begin
            trial = {r, sh[nars_pkg::SHIFT_W-1]};
            sh    = sh << 1;
            if (trial >= cnt_reg) begin
                trial = trial - cnt_reg;
            end
            r = trial[nars_pkg::DEV_IDX_W-1:0];
        end
        rem_next = r;
        sum_next = sh;
    end

    // walk the pool for the rem-th set bit
    logic [nars_pkg::CNT_W-1:0]     seen;
    logic                           found;
    logic [nars_pkg::DEV_IDX_W-1:0] pick_idx;

    always_comb begin
        seen     = '0;
        found    = 1'b0;
        pick_idx = '0;
        for (int i = 0; i < ND; i++) begin
            if (pool_reg[i] && !found) begin
                if (seen == nars_pkg::CNT_W'(rem_reg)) begin
                    found    = 1'b1;
                    pick_idx = nars_pkg::DEV_IDX_W'(i);
                end
                seen = seen + 1'b1;
            end
        end
    end

    logic                           res_valid;
    logic [nars_pkg::DEV_IDX_W-1:0] res_index;
    logic [7:0]                     res_allowed;
    logic [7:0]                     res_fallback;
    logic [1:0]                     res_locality;
    logic                           pick_ok;

    assign pick_ok = (mode_reg == nars_pkg::MODE_SELECT) && (cnt_reg != '0);

    always_comb begin
        res_valid    = 1'b0;
        res_index    = '0;
        res_allowed  = '0;
        res_fallback = '0;
        res_locality = nars_pkg::LOC_NONE;
        if (pick_ok) begin
            res_valid = 1'b1;
            res_index = pick_idx;
        end
        if (mode_reg == nars_pkg::MODE_CAND) begin
            res_allowed = 8'(live_reg);
            if (aware_reg) begin
                if (!known_reg) begin
                    res_locality = nars_pkg::LOC_UNKNOWN;
                end else if (local_reg == '0) begin
                    res_locality = nars_pkg::LOC_REMOTE;
                end else begin
                    res_locality = nars_pkg::LOC_LOCAL;
                    res_fallback = 8'(live_reg);
                    res_allowed  = 8'(local_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_count_reg <= '0;
            dev_nodes_reg <= '1;
            enable_reg    <= '1;
            turn_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == nars_pkg::REG_DEVICE_COUNT) begin
                    dev_count_reg <= cfg_wdata[nars_pkg::COUNT_W-1:0];
                end else begin
                    dev_nodes_reg <= cfg_wdata[nars_pkg::NODES_W-1:0];
                end
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
                if (pick_ok) begin
                    turn_reg <= turn_reg + 1'b1;
                end
                if ((mode_reg == nars_pkg::MODE_DISABLE) &&
                    (nars_pkg::COUNT_W'(target_reg) < present_cnt)) begin
                    enable_reg[target_reg] <= 1'b0;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= s_tuser;
            known_reg  <= in_known;
            aware_reg  <= in_aware;
            target_reg <= in_target;
            live_reg   <= live;
            local_reg  <= local_live;
            pool_reg   <= pool;
            cnt_reg    <= pool_cnt;
            rem_reg    <= '0;
            sum_reg    <= nars_pkg::SHIFT_W'({1'b0, turn_reg} +
                                             nars_pkg::SUM_W'(in_retry));
        end else if (cmd.reduce) begin
            rem_reg <= rem_next;
            sum_reg <= sum_next;
        end
        if (cmd.commit) begin
            m_data_reg <= {2'b00, res_locality, res_fallback, res_allowed,
                           res_index, res_valid};
        end
    end

    assign m_tdata  = m_data_reg;
    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

[rtl/core/numa_aware_round_robin_selector_unit.sv]
`default_nettype none

// Locality-aware round-robin device selector. A request in select mode picks
// an enabled, present device round-robin, restricted to devices on the
// caller's node when locality is asked for and such devices exist; candidate
// mode reports the allowed and fallback masks with a locality code; disable
// mode clears one device's enable bit. Every request gives one result. A
// select request is loaded, reduced in the remainder unit (the 33-bit
// turn + retry sum, one byte per cycle) and committed; candidate and disable
// requests go from load straight to commit. A new request is taken only once
// the last is committed. A result waiting in the output register stalls only
// the commit cycle. The user must write configuration (cfg_wr_en/cfg_index/
// cfg_wdata) only while idle; the block itself does not enforce this.
module numa_aware_round_robin_selector_unit (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_wr_en,
    input  wire                             cfg_index,
    input  wire  [nars_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // caller_node[3:0], caller_node_known[4], locality_aware[5],
    // retry_offset[21:6], target_index[24:22], zero fill above
    input  wire  [nars_pkg::S_DATA_W-1:0]   s_tdata,
    // mode[1:0]
    input  wire  [nars_pkg::MODE_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // chosen_valid[0], chosen_index[3:1], allowed_mask[11:4],
    // fallback_mask[19:12], locality[21:20], zero fill above
    output logic [nars_pkg::M_DATA_W-1:0]   m_tdata
);

    nars_pkg::nars_cmd_t    cmd;
    nars_pkg::nars_status_t status;

    nars_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nars_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

[dv/tb_numa_aware_round_robin_selector_unit.sv]
`timescale 1ns / 1ps

module tb_numa_aware_round_robin_selector_unit;

    import nars_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned ITEMS_PER_PHASE = 75;
    localparam int unsigned PHASES          = 8;
    localparam int unsigned CYCLE_LIMIT     = 400000;

    // request fields as they sit in s_tdata, MSB first
    typedef struct packed {
        logic [2:0]  target;
        logic [15:0] retry;
        logic        aware;
        logic        known;
        logic [3:0]  node;
    } req_fields_t;

    // result fields as they sit in m_tdata, MSB first
    typedef struct packed {
        logic [1:0] locality;
        logic [7:0] fallback;
        logic [7:0] allowed;
        logic [2:0] chosen_index;
        logic       chosen_valid;
    } outcome_t;

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic             reg_sel;
        logic [CFG_W-1:0] reg_val;
        logic [MODE_W-1:0] mode;
        req_fields_t      f;
        logic             fixed;
        outcome_t         golden;
    } plan_row_t;

    localparam outcome_t NO_RESULT = '0;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [MODE_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    // shadow of the block's registers and state
    logic [COUNT_W-1:0]     dev_count_q;
    logic [NODES_W-1:0]     dev_nodes_q;
    logic [MAX_DEVICES-1:0] enable_q;
    logic [TURN_W-1:0]      turn_q;

    outcome_t    pending_outcomes[$];
    outcome_t    want, got;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    logic        sender_steady = 1'b0;

    plan_row_t directed_plan [24] = '{
        // empty table right after reset
        '{ROW_REQ, 1'b0, 32'd0, MODE_SELECT, '{3'd0, 16'hFFFF, 1'b1, 1'b1, 4'd0}, 1'b1,
          NO_RESULT},
        '{ROW_REQ, 1'b0, 32'd0, MODE_CAND, '{3'd0, 16'h0000, 1'b0, 1'b1, 4'd0}, 1'b1,
          NO_RESULT},
        '{ROW_REQ, 1'b0, 32'd0, MODE_CAND, '{3'd0, 16'h0000, 1'b1, 1'b0, 4'd0}, 1'b1,
          '{LOC_UNKNOWN, 8'h00, 8'h00, 3'd0, 1'b0}},
        '{ROW_REQ, 1'b0, 32'd0, MODE_CAND, '{3'd0, 16'h0000, 1'b1, 1'b1, 4'd14}, 1'b1,
          '{LOC_REMOTE, 8'h00, 8'h00, 3'd0, 1'b0}},
        '{ROW_REQ, 1'b0, 32'd0, MODE_UNUSED, '{3'd7, 16'hFFFF, 1'b1, 1'b1, 4'd14}, 1'b1,
          NO_RESULT},
        '{ROW_REQ, 1'b0, 32'd0, MODE_DISABLE, '{3'd0, 16'h0000, 1'b0, 1'b0, 4'd0}, 1'b1,
          NO_RESULT},
        // eight devices; device 7 on the unknown node
        '{ROW_CFG, REG_DEVICE_COUNT, 32'd8, MODE_SELECT, '0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_DEVICE_NODES, 32'hF210_3210, MODE_SELECT, '0, 1'b0, NO_RESULT},
        '{ROW_REQ, 1'b0, 32'd0, MODE_SELECT, '{3'd0, 16'h0000, 1'b1, 1'b1, 4'd0}, 1'b0,
          NO_RESULT},
        '{ROW_REQ, 1'b0, 32'd0, MODE_SELECT, '{3'd0, 16'h0001, 1'b1, 1'b1, 4'd15}, 1'b0,
          NO_RESULT},
        '{ROW_REQ, 1'b0, 32'd0, MODE_CAND, '{3'd0, 16'h0000, 1'b1, 1'b1, 4'd15}, 1'b0,
          NO_RESULT},
        '{ROW_REQ, 1'b0, 32'd0, MODE_CAND, '{3'd0, 16'h0000, 1'b1, 1'b1, 4'd2}, 1'b0,
          NO_RESULT},
        '{ROW_REQ, 1'b0, 32'd0, MODE_SELECT, '{3'd0, 16'hFFFF, 1'b0, 1'b1, 4'd1}, 1'b0,
          NO_RESULT},
        '{ROW_REQ, 1'b0, 32'd0, MODE_SELECT, '{3'd0, 16'h0007, 1'b1, 1'b0, 4'd1}, 1'b0,
          NO_RESULT},
        '{ROW_REQ, 1'b0, 32'd0, MODE_DISABLE, '{3'd6, 16'h0000, 1'b0, 1'b0, 4'd0}, 1'b0,
          NO_RESULT},
        '{ROW_REQ, 1'b0, 32'd0, MODE_CAND, '{3'd0, 16'h0000, 1'b1, 1'b1, 4'd2}, 1'b0,
          NO_RESULT},
        // count above the table size saturates
        '{ROW_CFG, REG_DEVICE_COUNT, 32'd15, MODE_SELECT, '0, 1'b0, NO_RESULT},
        '{ROW_REQ, 1'b0, 32'd0, MODE_CAND, '{3'd0, 16'h0000, 1'b0, 1'b1, 4'd0}, 1'b0,
          NO_RESULT},
        '{ROW_REQ, 1'b0, 32'd0, MODE_SELECT, '{3'd0, 16'hFFFF, 1'b1, 1'b1, 4'd1}, 1'b0,
          NO_RESULT},
        '{ROW_CFG, REG_DEVICE_COUNT, 32'd3, MODE_SELECT, '0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_DEVICE_NODES, 32'h0000_0000, MODE_SELECT, '0, 1'b0, NO_RESULT},
        // target beyond the present devices
        '{ROW_REQ, 1'b0, 32'd0, MODE_DISABLE, '{3'd5, 16'h0000, 1'b0, 1'b0, 4'd0}, 1'b0,
          NO_RESULT},
        '{ROW_REQ, 1'b0, 32'd0, MODE_CAND, '{3'd0, 16'h0000, 1'b1, 1'b1, 4'd0}, 1'b0,
          NO_RESULT},
        '{ROW_REQ, 1'b0, 32'd0, MODE_SELECT, '{3'd0, 16'h0001, 1'b1, 1'b1, 4'd0}, 1'b0,
          NO_RESULT}
    };

    numa_aware_round_robin_selector_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic outcome_t resolve_request(input logic [MODE_W-1:0] mode,
                                                 input req_fields_t f);
        outcome_t               o;
        logic [MAX_DEVICES-1:0] live, near, pool;
        logic [NODE_BITS-1:0]   dnode;
        logic [SUM_W-1:0]       sum;
        int unsigned            present, cnt, pick, seen;
        o       = '0;
        live    = '0;
        near    = '0;
        present = (dev_count_q > MAX_DEVICES) ? MAX_DEVICES : dev_count_q;
        for (int i = 0; i < present; i++) begin
            dnode   = dev_nodes_q[i*NODE_BITS +: NODE_BITS];
            live[i] = enable_q[i];
            near[i] = (dnode != NODE_UNKNOWN) && (dnode == f.node);
        end
        case (mode)
            MODE_SELECT: begin
                pool = (f.aware && f.known && (live & near) != '0) ? (live & near) : live;
                cnt  = $countones(pool);
                if (cnt != 0) begin
                    // sum kept 33 bits wide, no wrap before the modulo
                    sum    = {1'b0, turn_q} + SUM_W'(f.retry);
                    pick   = int'(sum % cnt);
                    turn_q = turn_q + 1'b1;
                    seen   = 0;
                    for (int i = 0; i < MAX_DEVICES; i++) begin
                        if (pool[i]) begin
                            if (seen == pick) begin
                                o.chosen_valid = 1'b1;
                                o.chosen_index = 3'(i);
                            end
                            seen++;
                        end
                    end
                end
            end
            MODE_CAND: begin
                o.allowed = live;
                if (f.aware) begin
                    if (!f.known) begin
                        o.locality = LOC_UNKNOWN;
                    end else if ((live & near) == '0) begin
                        o.locality = LOC_REMOTE;
                    end else begin
                        o.locality = LOC_LOCAL;
                        o.fallback = live;
                        o.allowed  = live & near;
                    end
                end
            end
            MODE_DISABLE: begin
                if (f.target < present) enable_q[f.target] = 1'b0;
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic sel, input logic [CFG_W-1:0] val);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val;
        @(posedge aclk);
        if (sel == REG_DEVICE_COUNT) dev_count_q = val[COUNT_W-1:0];
        else dev_nodes_q = val;
    endtask

    // cfg_wr_en is dropped here so back-to-back writes keep it high
    task automatic send_request(input logic [MODE_W-1:0] mode, input req_fields_t f,
                                input logic fixed, input outcome_t golden);
        outcome_t    predicted;
        int unsigned gap;
        cfg_wr_en <= 1'b0;
        s_tvalid  <= 1'b1;
        s_tuser   <= mode;
        s_tdata   <= S_DATA_W'(f);
        do @(posedge aclk); while (!s_tready);
        predicted = resolve_request(mode, f);
        pending_outcomes = {pending_outcomes, (fixed ? golden : predicted)};
        gap = sender_steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic report_field(input string name, input int unsigned e, input int unsigned a);
        if (e != a) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
            error_count++;
        end
    endtask

    // result sink: short stalls, a few long ones, and some long ready stretches
    initial begin
        int unsigned run_len, stall_len;
        forever begin
            if ($urandom_range(0, 7) == 0) begin
                run_len   = $urandom_range(40, 100);
                stall_len = 0;
            end else begin
                run_len   = $urandom_range(1, 12);
                stall_len = pick_gap();
            end
            m_tready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            if (stall_len != 0) begin
                m_tready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, m_tdata);
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                got  = outcome_t'(m_tdata[$bits(outcome_t)-1:0]);
                report_field("chosen_valid",  want.chosen_valid, got.chosen_valid);
                report_field("chosen_index",  want.chosen_index, got.chosen_index);
                report_field("allowed_mask",  want.allowed,      got.allowed);
                report_field("fallback_mask", want.fallback,     got.fallback);
                report_field("locality",      want.locality,     got.locality);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [COUNT_W-1:0]   count;
        logic [NODES_W-1:0]   nodes;
        logic [MODE_W-1:0]    mode;
        req_fields_t          f;
        int unsigned          r, dev;

        dev_count_q = '0;
        dev_nodes_q = '1;
        enable_q    = '1;
        turn_q      = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[k]) begin
            if (directed_plan[k].kind == ROW_CFG)
                write_reg(directed_plan[k].reg_sel, directed_plan[k].reg_val);
            else
                send_request(directed_plan[k].mode, directed_plan[k].f,
                             directed_plan[k].fixed, directed_plan[k].golden);
        end

        for (int p = 0; p < PHASES; p++) begin
            nodes = '0;
            for (int i = 0; i < MAX_DEVICES; i++) begin
                r = $urandom_range(0, 9);
                if (r < 6) nodes[i*NODE_BITS +: NODE_BITS] = 4'($urandom_range(0, 2));
                else if (r < 8) nodes[i*NODE_BITS +: NODE_BITS] = NODE_UNKNOWN;
                else nodes[i*NODE_BITS +: NODE_BITS] = 4'($urandom_range(0, 14));
            end
            case (p)
                0: begin
                    count = 4'd8;
                    nodes = '0;
                end
                1: begin
                    count = 4'd15;
                    nodes = '1;
                end
                2: count = 4'd0;
                3: count = 4'd1;
                default: count = 4'($urandom_range(2, 8));
            endcase
            write_reg(REG_DEVICE_COUNT, CFG_W'(count));
            write_reg(REG_DEVICE_NODES, nodes);
            sender_steady = ($urandom_range(0, 3) == 0);

            repeat (ITEMS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 55) mode = MODE_SELECT;
                else if (r < 98) mode = MODE_CAND;
                else mode = MODE_DISABLE;
                // mostly ask from a node some device actually sits on
                dev = $urandom_range(0, MAX_DEVICES - 1);
                if ($urandom_range(0, 9) < 7)
                    f.node = dev_nodes_q[dev*NODE_BITS +: NODE_BITS];
                else
                    f.node = 4'($urandom_range(0, 14));
                if (f.node == NODE_UNKNOWN) f.node = 4'($urandom_range(0, 14));
                f.known  = ($urandom_range(0, 4) != 0);
                f.aware  = ($urandom_range(0, 4) != 0);
                r = $urandom_range(0, 9);
                if (r == 0) f.retry = 16'h0000;
                else if (r == 1) f.retry = 16'hFFFF;
                else f.retry = 16'($urandom);
                f.target = 3'($urandom_range(0, 7));
                send_request(mode, f, 1'b0, NO_RESULT);
            end
        end

        wait_drained();
        repeat (16) @(posedge aclk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
